// File: rtl/otp_pkg.sv
// ----------------------------------------------------------------------------
// otp_pkg
// Shared constants and types of the one-shot timer pool.
// ----------------------------------------------------------------------------
package otp_pkg;

    localparam int POOL_SIZE = 8;
    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int OP_W      = 3;
    localparam int SLOT_W    = 4;
    localparam int DATA_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_CREATE   = 3'd1,
        OP_SET_IVAL = 3'd2,
        OP_START    = 3'd3,
        OP_STOP     = 3'd4,
        OP_DESTROY  = 3'd5
    } t_opcode;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

endpackage

// File: rtl/otp_ifs.sv
// ----------------------------------------------------------------------------
// otp_ifs
// Command and result channels of the one-shot timer pool.
// ----------------------------------------------------------------------------
interface otp_cmd_if import otp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] target_id;
    logic [DATA_W-1:0] interval;

    modport source (output valid, opcode, target_id, interval, input ready);
    modport sink   (input valid, opcode, target_id, interval, output ready);
endinterface

interface otp_res_if import otp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [SLOT_W-1:0] slot_id;
    logic              fired;
    logic              last;

    modport source (output valid, status, slot_id, fired, last, input ready);
    modport sink   (input valid, status, slot_id, fired, last, output ready);
endinterface

// File: rtl/oneshot_timer_pool.sv
// ----------------------------------------------------------------------------
// oneshot_timer_pool
// Pool of one-shot countdown timers. Intervals and remaining counts sit in
// two RAMs; slot state is kept as used/running bits.
// Results: a command result is registered from S_EXEC; a start first reads
// its interval and registers its result from S_SLOAD. Tick: sweeps the
// remaining-count RAM one slot per cycle unless a pending expiry stalls on
// the result channel; expiries come in slot order. One item at a time:
// no new command is taken until the last is done; result stalls hold it.
// Reset: all slots free, no clearing pass; ready straight out of reset.
// ----------------------------------------------------------------------------
module oneshot_timer_pool import otp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    otp_cmd_if.sink   i_cmd,
    otp_res_if.source o_res
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_TRD   = 6'b000010,
        S_TWB   = 6'b000100,
        S_TEND  = 6'b001000,
        S_EXEC  = 6'b010000,
        S_SLOAD = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_opcode           r_op, n_op;
    logic [SLOT_W-1:0] r_id, n_id;
    logic [DATA_W-1:0] r_ival, n_ival;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [POOL_SIZE-1:0] r_used, n_used;
    logic [POOL_SIZE-1:0] r_run, n_run;
    logic              r_pend_v, n_pend_v;
    logic [IDX_W-1:0]  r_pend_id, n_pend_id;

    logic              r_out_valid, n_out_valid;
    logic              r_out_status, n_out_status;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_fired, n_out_fired;
    logic              r_out_last, n_out_last;

    logic              ival_we, ival_re;
    logic [IDX_W-1:0]  ival_waddr;
    logic [DATA_W-1:0] ival_rdata;
    logic              rem_we, rem_re;
    logic [IDX_W-1:0]  rem_waddr, rem_raddr;
    logic [DATA_W-1:0] rem_wdata, rem_rdata;

    logic              emit, e_status, e_fired, e_last;
    logic [SLOT_W-1:0] e_slot;

    logic              out_free, id_ok, has_free, tick_fire, twb_stall, cmd_ok;
    logic [IDX_W-1:0]  id_ix, free_ix, idx_inc;
    logic [DATA_W-1:0] rem_dec;

    otp_ram #(.WIDTH(DATA_W), .DEPTH(POOL_SIZE)) u_ival_ram (
        .i_clk   (i_clk),
        .i_we    (ival_we),
        .i_waddr (ival_waddr),
        .i_wdata (r_ival),
        .i_re    (ival_re),
        .i_raddr (id_ix),
        .o_rdata (ival_rdata)
    );

    otp_ram #(.WIDTH(DATA_W), .DEPTH(POOL_SIZE)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (rem_waddr),
        .i_wdata (rem_wdata),
        .i_re    (rem_re),
        .i_raddr (rem_raddr),
        .o_rdata (rem_rdata)
    );

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.slot_id = r_out_slot;
    assign o_res.fired   = r_out_fired;
    assign o_res.last    = r_out_last;

    assign out_free  = !r_out_valid || o_res.ready;
    assign id_ok     = {1'b0, r_id} < (SLOT_W + 1)'(POOL_SIZE);
    assign id_ix     = r_id[IDX_W-1:0];
    assign idx_inc   = IDX_W'(r_idx + IDX_W'(1));
    assign rem_dec   = rem_rdata - DATA_W'(1);
    assign tick_fire = r_run[r_idx] && (rem_dec == '0);
    assign twb_stall = tick_fire && r_pend_v && !out_free;

    // lowest free slot
    always_comb begin
        has_free = 1'b0;
        free_ix  = '0;
        for (int i = POOL_SIZE - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                has_free = 1'b1;
                free_ix  = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_ival     = r_ival;
        n_idx      = r_idx;
        n_used     = r_used;
        n_run      = r_run;
        n_pend_v   = r_pend_v;
        n_pend_id  = r_pend_id;
        ival_we    = 1'b0;
        ival_re    = 1'b0;
        ival_waddr = id_ix;
        rem_we     = 1'b0;
        rem_re     = 1'b0;
        rem_waddr  = r_idx;
        rem_wdata  = rem_dec;
        rem_raddr  = r_idx;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_slot     = r_id;
        e_fired    = 1'b0;
        e_last     = 1'b1;
        cmd_ok     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op   = t_opcode'(i_cmd.opcode);
                    n_id   = i_cmd.target_id;
                    n_ival = i_cmd.interval;
                    n_idx  = '0;
                    if (t_opcode'(i_cmd.opcode) == OP_TICK) begin
                        n_state = S_TRD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_TRD: begin
                rem_re  = 1'b1;
                n_state = S_TWB;
            end
            S_TWB: begin
                if (!twb_stall) begin
                    rem_we = r_run[r_idx];
                    if (tick_fire) begin
                        n_run[r_idx] = 1'b0;
                        n_pend_v     = 1'b1;
                        n_pend_id    = r_idx;
                        if (r_pend_v) begin
                            emit    = 1'b1;
                            e_slot  = SLOT_W'(r_pend_id);
                            e_fired = 1'b1;
                            e_last  = 1'b0;
                        end
                    end
                    if (r_idx == IDX_W'(POOL_SIZE - 1)) begin
                        n_state = S_TEND;
                    end else begin
                        n_idx     = idx_inc;
                        rem_re    = 1'b1;
                        rem_raddr = idx_inc;
                    end
                end
            end
            S_TEND: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    emit     = 1'b1;
                    e_slot   = SLOT_W'(r_pend_id);
                    e_fired  = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_CREATE: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                            if (has_free) begin
                                n_used[free_ix] = 1'b1;
                                ival_we    = 1'b1;
                                ival_waddr = free_ix;
                                e_slot     = SLOT_W'(free_ix);
                            end else begin
                                e_status = ST_ERR;
                                e_slot   = '0;
                            end
                        end
                    end
                    OP_SET_IVAL: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            n_state  = S_IDLE;
                            ival_we  = id_ok;
                            e_status = id_ok ? ST_OK : ST_ERR;
                        end
                    end
                    OP_START: begin
                        if (id_ok && r_used[id_ix] && !r_run[id_ix]) begin
                            ival_re = 1'b1;
                            n_state = S_SLOAD;
                        end else if (out_free) begin
                            emit     = 1'b1;
                            e_status = ST_ERR;
                            n_state  = S_IDLE;
                        end
                    end
                    OP_STOP: begin
                        if (out_free) begin
                            cmd_ok   = id_ok && r_run[id_ix];
                            emit     = 1'b1;
                            n_state  = S_IDLE;
                            e_status = cmd_ok ? ST_OK : ST_ERR;
                            if (cmd_ok) begin
                                n_run[id_ix] = 1'b0;
                            end
                        end
                    end
                    OP_DESTROY: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            n_state  = S_IDLE;
                            e_status = id_ok ? ST_OK : ST_ERR;
                            if (id_ok) begin
                                n_used[id_ix] = 1'b0;
                                n_run[id_ix]  = 1'b0;
                            end
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit     = 1'b1;
                            e_status = ST_ERR;
                            e_slot   = '0;
                            n_state  = S_IDLE;
                        end
                    end
                endcase
            end
            S_SLOAD: begin
                if (out_free) begin
                    rem_we       = 1'b1;
                    rem_waddr    = id_ix;
                    rem_wdata    = ival_rdata;
                    n_run[id_ix] = 1'b1;
                    emit         = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_fired  = r_out_fired;
        n_out_last   = r_out_last;
        if (emit) begin
            n_out_valid  = 1'b1;
            n_out_status = e_status;
            n_out_slot   = e_slot;
            n_out_fired  = e_fired;
            n_out_last   = e_last;
        end else if (o_res.ready) begin
            n_out_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_run       <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_run       <= n_run;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_ival       <= n_ival;
        r_idx        <= n_idx;
        r_pend_id    <= n_pend_id;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_fired  <= n_out_fired;
        r_out_last   <= n_out_last;
    end

endmodule

// File: rtl/otp_ram.sv
// ----------------------------------------------------------------------------
// otp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/otp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// otp_checker
// Watches the command and result channels of the timer pool. It keeps its
// own copy of every slot, works out the result items of each accepted
// command and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module otp_checker import otp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    otp_cmd_if   i_cmd,
    otp_res_if   i_res,
    output int   o_errors,
    output int   o_pending
);

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_STOPPED = 2'd1,
        SLOT_RUNNING = 2'd2
    } t_slot_state;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] slot_id;
        logic              fired;
        logic              last;
    } t_timer_result;

    t_slot_state       slot_st   [POOL_SIZE];
    logic [DATA_W-1:0] slot_ival [POOL_SIZE];
    logic [DATA_W-1:0] slot_left [POOL_SIZE];
    t_timer_result     due_results[$];
    int                err_cnt = 0;

    function automatic void queue_result(input logic status, input logic [SLOT_W-1:0] id,
                                         input logic fired, input logic last);
        t_timer_result r;
        r.status  = status;
        r.slot_id = id;
        r.fired   = fired;
        r.last    = last;
        due_results.push_back(r);
    endfunction

    function automatic void apply_timer_cmd(input logic [OP_W-1:0] op,
                                            input logic [SLOT_W-1:0] id,
                                            input logic [DATA_W-1:0] ival);
        int   last_hit;
        int   slot;
        logic in_range;
        logic failed;
        logic echo;
        logic [IDX_W-1:0] ix;
        last_hit = -1;
        slot     = -1;
        in_range = int'(id) < POOL_SIZE;
        failed   = 1'b1;
        echo     = 1'b1;
        ix       = id[IDX_W-1:0];
        case (op)
            OP_TICK: begin
                echo = 1'b0;
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (slot_st[i] == SLOT_RUNNING && slot_left[i] == 1) last_hit = i;
                end
                for (int i = 0; i < POOL_SIZE; i++) begin
                    if (slot_st[i] == SLOT_RUNNING) begin
                        slot_left[i] = slot_left[i] - 1'b1;
                        if (slot_left[i] == '0) begin
                            slot_st[i] = SLOT_STOPPED;
                            queue_result(ST_OK, SLOT_W'(i), 1'b1, i == last_hit);
                        end
                    end
                end
            end
            OP_CREATE: begin
                echo = 1'b0;
                for (int i = POOL_SIZE - 1; i >= 0; i--) begin
                    if (slot_st[i] == SLOT_FREE) slot = i;
                end
                if (slot >= 0) begin
                    slot_st[slot]   = SLOT_STOPPED;
                    slot_ival[slot] = ival;
                    queue_result(ST_OK, SLOT_W'(slot), 1'b0, 1'b1);
                end else begin
                    queue_result(ST_ERR, '0, 1'b0, 1'b1);
                end
            end
            OP_SET_IVAL: begin
                if (in_range) begin
                    slot_ival[ix] = ival;
                    failed        = 1'b0;
                end
            end
            OP_START: begin
                if (in_range) begin
                    if (slot_st[ix] == SLOT_STOPPED) begin
                        slot_left[ix] = slot_ival[ix];
                        slot_st[ix]   = SLOT_RUNNING;
                        failed        = 1'b0;
                    end
                end
            end
            OP_STOP: begin
                if (in_range) begin
                    if (slot_st[ix] == SLOT_RUNNING) begin
                        slot_st[ix] = SLOT_STOPPED;
                        failed      = 1'b0;
                    end
                end
            end
            OP_DESTROY: begin
                if (in_range) begin
                    slot_st[ix] = SLOT_FREE;
                    failed      = 1'b0;
                end
            end
            default: begin
                echo = 1'b0;
                queue_result(ST_ERR, '0, 1'b0, 1'b1);
            end
        endcase
        if (echo) queue_result(failed ? ST_ERR : ST_OK, id, 1'b0, 1'b1);
    endfunction

    function automatic void check_result();
        t_timer_result want;
        if (due_results.size() == 0) begin
            $error("unexpected result: status %0d slot_id %0d fired %0d last %0d",
                   i_res.status, i_res.slot_id, i_res.fired, i_res.last);
            err_cnt++;
        end else begin
            want = due_results.pop_front();
            if (i_res.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, i_res.status);
                err_cnt++;
            end
            if (i_res.slot_id !== want.slot_id) begin
                $error("slot_id: expected %0d, actual %0d", want.slot_id, i_res.slot_id);
                err_cnt++;
            end
            if (i_res.fired !== want.fired) begin
                $error("fired: expected %0d, actual %0d", want.fired, i_res.fired);
                err_cnt++;
            end
            if (i_res.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, i_res.last);
                err_cnt++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_SIZE; i++) begin
                slot_st[i]   = SLOT_FREE;
                slot_ival[i] = '0;
                slot_left[i] = '0;
            end
            due_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                apply_timer_cmd(i_cmd.opcode, i_cmd.target_id, i_cmd.interval);
            end
            if (i_res.valid && i_res.ready) check_result();
        end
        o_errors  <= err_cnt;
        o_pending <= due_results.size();
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the one-shot timer pool: a directed opening over the corner
// cases, then random timer episodes mixed with noise, with stall bursts on
// both channels. The checker beside the block counts the mismatches.
// ----------------------------------------------------------------------------
module tb;
    import otp_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam int ITEM_COUNT   = 110;
    localparam int QUIET_TAIL   = 25;
    localparam int SETTLE       = POOL_SIZE + 8;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   sent = 0;
    logic quiet = 1'b0;

    otp_cmd_if cmd_ch ();
    otp_res_if res_ch ();

    oneshot_timer_pool i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    otp_checker i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [DATA_W-1:0] pick_interval();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return $urandom();
        return $urandom_range(1, 4);
    endfunction

    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] id,
                            input logic [DATA_W-1:0] ival);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.opcode    <= op;
        cmd_ch.target_id <= id;
        cmd_ch.interval  <= ival;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int   stop_at;
        int   roll;
        logic paused;
        logic [SLOT_W-1:0] id;
        paused           = 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.opcode    <= OP_TICK;
        cmd_ch.target_id <= '0;
        cmd_ch.interval  <= '0;
        i_rst_n          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pool, then fill it and overflow
        send_cmd(OP_TICK, 4'd0, 32'd0);
        send_cmd(OP_START, 4'd0, 32'd0);
        send_cmd(OP_CREATE, 4'd0, 32'd1);
        send_cmd(OP_CREATE, 4'd0, 32'd2);
        send_cmd(OP_CREATE, 4'd0, 32'd3);
        send_cmd(OP_CREATE, 4'd0, 32'd0);
        send_cmd(OP_CREATE, 4'd0, 32'hFFFF_FFFF);
        send_cmd(OP_CREATE, 4'd0, 32'd1);
        send_cmd(OP_CREATE, 4'd0, 32'd1);
        send_cmd(OP_CREATE, 4'd0, 32'd2);
        send_cmd(OP_CREATE, 4'd0, 32'h1234_5678);
        send_cmd(OP_SET_IVAL, 4'd15, 32'hAAAA_AAAA);
        send_cmd(OP_SET_IVAL, 4'd8, 32'h5555_5555);
        // slot 3 starts with zero interval and wraps
        send_cmd(OP_START, 4'd0, 32'd0);
        send_cmd(OP_START, 4'd3, 32'd0);
        send_cmd(OP_START, 4'd5, 32'd0);
        send_cmd(OP_START, 4'd6, 32'd0);
        send_cmd(OP_START, 4'd0, 32'd0);
        send_cmd(OP_STOP, 4'd7, 32'd0);
        send_cmd(OP_TICK, 4'd0, 32'd0);
        send_cmd(OP_STOP, 4'd3, 32'd0);
        send_cmd(OP_DESTROY, 4'd15, 32'd0);
        send_cmd(OP_DESTROY, 4'd1, 32'd0);
        send_cmd(OP_CREATE, 4'd0, 32'd4);
        send_cmd(OP_RSVD_6, 4'd3, 32'd0);
        send_cmd(OP_RSVD_7, 4'd15, 32'hFFFF_FFFF);

        stop_at = ITEM_COUNT;

        // every slot expires on the same tick
        for (int s = 0; s < POOL_SIZE; s++) begin
            send_cmd(OP_STOP, SLOT_W'(s), $urandom());
            send_cmd(OP_SET_IVAL, SLOT_W'(s), 32'd1);
            send_cmd(OP_START, SLOT_W'(s), $urandom());
        end
        send_cmd(OP_TICK, SLOT_W'($urandom_range(0, 15)), $urandom());

        while (sent < stop_at) begin
            if (sent >= stop_at - QUIET_TAIL) quiet = 1'b1;
            if (!paused && sent >= stop_at - ITEM_COUNT / 2) begin
                drain();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                repeat ($urandom_range(1, 3)) begin
                    id = SLOT_W'($urandom_range(0, POOL_SIZE - 1));
                    send_cmd(OP_STOP, id, $urandom());
                    send_cmd(OP_SET_IVAL, id, $urandom_range(1, 4));
                    send_cmd(OP_START, id, $urandom());
                end
                repeat ($urandom_range(1, 5)) begin
                    send_cmd(OP_TICK, SLOT_W'($urandom_range(0, 15)), $urandom());
                end
            end else if (roll == 6) begin
                send_cmd(OP_DESTROY, SLOT_W'($urandom_range(0, 15)), $urandom());
                send_cmd(OP_CREATE, SLOT_W'($urandom_range(0, 15)), pick_interval());
            end else if (roll == 7) begin
                send_cmd(OP_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 15)),
                         pick_interval());
            end else if (roll == 8) begin
                send_cmd(OP_TICK, SLOT_W'($urandom_range(0, 15)), $urandom());
            end else begin
                send_cmd(OP_CREATE, SLOT_W'($urandom_range(0, 15)), pick_interval());
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
